// ===== rtl/srt_process_scheduler_macros.svh =====
// assertion macros for the scheduler rtl
`ifndef SRT_PROCESS_SCHEDULER_MACROS_SVH
`define SRT_PROCESS_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SRT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("srt scheduler: same-cycle check failed");
// next-cycle implication
`define SRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("srt scheduler: next-cycle check failed");
`else
`define SRT_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/srt_pkg.sv =====
package srt_pkg;

    localparam int DEF_MAX_SLOTS = 64;
    localparam int DEF_TIME_BITS = 24;

    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 6;
    localparam int BURST_W    = 16;
    localparam int OUT_TIME_W = 24;
    localparam int COUNT_W    = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 128;
    localparam int M_USER_W   = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic REG_ACTIVE_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] ACTIVE_COUNT_RESET = 7'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD,
        ST_FIN
    } srt_state_t;

    // control flags of the candidate travelling along the cell row
    typedef struct packed {
        logic valid;
        logic found;
        logic started;
    } scan_ctl_t;

    // broadcast commands from the sequencer to every cell
    typedef struct packed {
        logic load;
        logic restart;
        logic update;
    } cell_cmd_t;

endpackage

// ===== rtl/srt_cell.sv =====
module srt_cell #(
    parameter int IDX       = 0,
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7,
    parameter int TIME_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  srt_pkg::cell_cmd_t      cmd,
    input  logic [IDX_W-1:0]        load_idx,
    input  logic [15:0]             load_arr,
    input  logic [15:0]             load_bst,
    input  logic [IDX_W-1:0]        upd_idx,
    input  logic [TIME_BITS-1:0]    upd_rsp,
    input  logic [TIME_BITS-1:0]    clock_now,
    input  logic [CNT_W-1:0]        eff_count,
    input  srt_pkg::scan_ctl_t      in_ctl,
    input  logic [15:0]             in_rem,
    input  logic [IDX_W-1:0]        in_idx,
    input  logic [15:0]             in_arr,
    input  logic [15:0]             in_bst,
    input  logic [TIME_BITS-1:0]    in_rsp,
    output srt_pkg::scan_ctl_t      out_ctl,
    output logic [15:0]             out_rem,
    output logic [IDX_W-1:0]        out_idx,
    output logic [15:0]             out_arr,
    output logic [15:0]             out_bst,
    output logic [TIME_BITS-1:0]    out_rsp
);
    import srt_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [15:0]          arr_reg;
    logic [15:0]          bst_reg;
    logic [15:0]          rem_reg;
    logic                 started_reg;
    logic [TIME_BITS-1:0] rsp_reg;

    scan_ctl_t            ctl_reg, ctl_next;
    logic [15:0]          trem_reg, trem_next;
    logic [IDX_W-1:0]     tidx_reg, tidx_next;
    logic [15:0]          tarr_reg, tarr_next;
    logic [15:0]          tbst_reg, tbst_next;
    logic [TIME_BITS-1:0] trsp_reg, trsp_next;

    logic eligible;
    logic take;
    logic hit_upd;

    assign eligible = (CNT_W'(IDX) < eff_count) && (TIME_BITS'(arr_reg) <= clock_now)
                      && (rem_reg != 16'd0);
    // strict compare keeps the earlier, lower slot on a tie
    assign take     = eligible && (!in_ctl.found || (rem_reg < in_rem));
    assign hit_upd  = cmd.update && (upd_idx == MY_IDX);

    always_comb begin
        ctl_next.valid = in_ctl.valid;
        if (take) begin
            ctl_next.found   = 1'b1;
            ctl_next.started = started_reg;
            trem_next        = rem_reg;
            tidx_next        = MY_IDX;
            tarr_next        = arr_reg;
            tbst_next        = bst_reg;
            trsp_next        = rsp_reg;
        end else begin
            ctl_next.found   = in_ctl.found;
            ctl_next.started = in_ctl.started;
            trem_next        = in_rem;
            tidx_next        = in_idx;
            tarr_next        = in_arr;
            tbst_next        = in_bst;
            trsp_next        = in_rsp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg     <= '0;
            rem_reg     <= '0;
            started_reg <= 1'b0;
        end else begin
            ctl_reg <= ctl_next;
            if (cmd.restart) begin
                rem_reg     <= bst_reg;
                started_reg <= 1'b0;
            end else if (hit_upd) begin
                rem_reg     <= rem_reg - 16'd1;
                started_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        trem_reg <= trem_next;
        tidx_reg <= tidx_next;
        tarr_reg <= tarr_next;
        tbst_reg <= tbst_next;
        trsp_reg <= trsp_next;
        if (cmd.load && (load_idx == MY_IDX)) begin
            arr_reg <= load_arr;
            bst_reg <= load_bst;
        end
        if (hit_upd && !started_reg) begin
            rsp_reg <= upd_rsp;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_rem = trem_reg;
    assign out_idx = tidx_reg;
    assign out_arr = tarr_reg;
    assign out_bst = tbst_reg;
    assign out_rsp = trsp_reg;

endmodule

// ===== rtl/srt_process_scheduler.sv =====
// Preemptive shortest-remaining-time scheduler. Each process slot lives in its own cell of a
// row; a tick beat sends a candidate token from cell 0 to the last cell, one cell per cycle,
// each cell swapping in its own slot when it has arrived, is unfinished and has strictly less
// remaining time, so ties go to the lowest slot. After the accepting edge a tick walks the row
// (scan state), charges the chosen slot and advances the clock (update state), then forms the
// waiting time and loads the result register (finish state), where it waits for as long as the
// previous result still sits unaccepted in the result register. The next beat is taken once
// the sequencer is back in idle. Load and restart beats give no result; restart copies every
// burst into the remaining time as the beat is accepted. One tick is handled at a time; a
// finished result may sit in the output register while the next beat is taken. The time
// counter stops at its maximum. active_count sits at byte address 0 of the register port and
// should only be written while the block is idle.
`include "srt_process_scheduler_macros.svh"

module srt_process_scheduler #(
    parameter int MAX_SLOTS = srt_pkg::DEF_MAX_SLOTS,
    parameter int TIME_BITS = srt_pkg::DEF_TIME_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beats
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot[5:0], arrival[21:6], burst[37:22], zero pad
    input  logic [srt_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // command[1:0]
    input  logic [srt_pkg::CMD_W-1:0]       s_axis_tuser,
    // result beats
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tick_time[23:0], ran_slot[29:24], done_time[53:30], turnaround[77:54],
    // waiting[101:78], response[125:102], all_done[126], zero pad
    output logic [srt_pkg::M_DATA_W-1:0]    m_axis_tdata,
    // idle[0], finished[1]
    output logic [srt_pkg::M_USER_W-1:0]    m_axis_tuser,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [srt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [srt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [srt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import srt_pkg::*;

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    // sequencer and global state
    srt_state_t           state_reg, state_next;
    logic [TIME_BITS-1:0] clock_reg;
    logic [CNT_W-1:0]     completed_reg;
    logic [COUNT_W-1:0]   active_count_reg;

    // token captured at the end of the row
    scan_ctl_t            hold_ctl_reg;
    logic [15:0]          hold_rem_reg;
    logic [IDX_W-1:0]     hold_idx_reg;
    logic [15:0]          hold_arr_reg;
    logic [15:0]          hold_bst_reg;
    logic [TIME_BITS-1:0] hold_rsp_reg;

    // tick outcome, formed in the charge cycle
    logic [TIME_BITS-1:0] res_tick_reg;
    logic                 res_idle_reg;
    logic [IDX_W-1:0]     res_slot_reg;
    logic                 res_fin_reg;
    logic [TIME_BITS-1:0] res_comp_reg;
    logic [TIME_BITS-1:0] res_tat_reg;
    logic [TIME_BITS-1:0] res_rsp_reg;

    // result register
    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [M_USER_W-1:0]   m_tuser_reg, m_tuser_next;

    // handshake decode
    logic                 s_accept;
    logic                 tick_start;
    logic                 do_restart;
    logic                 do_load;
    logic                 cfg_write;
    logic                 out_free;
    logic                 out_load;
    logic                 charge;
    logic                 fin_now;
    logic [TIME_BITS-1:0] clock_inc;
    logic [TIME_BITS-1:0] rsp_new;
    logic [TIME_BITS-1:0] wait_time;
    logic [CNT_W-1:0]     eff_count;
    logic                 all_done;
    cell_cmd_t            cell_cmd;

    // candidate chain taps, one more than there are cells
    scan_ctl_t            ctl_chain [0:MAX_SLOTS];
    logic [15:0]          rem_chain [0:MAX_SLOTS];
    logic [IDX_W-1:0]     idx_chain [0:MAX_SLOTS];
    logic [15:0]          arr_chain [0:MAX_SLOTS];
    logic [15:0]          bst_chain [0:MAX_SLOTS];
    logic [TIME_BITS-1:0] rsp_chain [0:MAX_SLOTS];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign tick_start    = s_accept && (s_axis_tuser == CMD_TICK);
    assign do_restart    = s_accept && (s_axis_tuser == CMD_RESTART);
    // loads beyond the table are dropped
    assign do_load       = s_accept && (s_axis_tuser == CMD_LOAD)
                           && (32'(s_axis_tdata[5:0]) < 32'(MAX_SLOTS));

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ACTIVE_COUNT) ? APB_DATA_W'(active_count_reg) : '0;

    // counts above the table size act as the table size
    assign eff_count = (32'(active_count_reg) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                                : CNT_W'(active_count_reg);

    assign clock_inc = (clock_reg == '1) ? clock_reg : clock_reg + 1'b1;
    assign rsp_new   = clock_reg - TIME_BITS'(hold_arr_reg);
    assign charge    = (state_reg == ST_UPD) && hold_ctl_reg.found;
    assign fin_now   = charge && (hold_rem_reg == 16'd1);
    // turnaround below burst can happen after clock saturation
    assign wait_time = (res_tat_reg > TIME_BITS'(hold_bst_reg))
                       ? res_tat_reg - TIME_BITS'(hold_bst_reg) : '0;
    assign all_done  = (completed_reg >= eff_count);
    assign out_free  = !m_tvalid_reg || m_axis_tready;

    assign cell_cmd.load    = do_load;
    assign cell_cmd.restart = do_restart;
    assign cell_cmd.update  = charge;

    // head of the row: a fresh token with nothing found
    assign ctl_chain[0] = '{valid: tick_start, found: 1'b0, started: 1'b0};
    assign rem_chain[0] = '0;
    assign idx_chain[0] = '0;
    assign arr_chain[0] = '0;
    assign bst_chain[0] = '0;
    assign rsp_chain[0] = '0;

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        srt_cell #(
            .IDX       (g),
            .IDX_W     (IDX_W),
            .CNT_W     (CNT_W),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cell_cmd),
            .load_idx  (IDX_W'(s_axis_tdata[5:0])),
            .load_arr  (s_axis_tdata[21:6]),
            .load_bst  (s_axis_tdata[37:22]),
            .upd_idx   (hold_idx_reg),
            .upd_rsp   (rsp_new),
            .clock_now (clock_reg),
            .eff_count (eff_count),
            .in_ctl    (ctl_chain[g]),
            .in_rem    (rem_chain[g]),
            .in_idx    (idx_chain[g]),
            .in_arr    (arr_chain[g]),
            .in_bst    (bst_chain[g]),
            .in_rsp    (rsp_chain[g]),
            .out_ctl   (ctl_chain[g+1]),
            .out_rem   (rem_chain[g+1]),
            .out_idx   (idx_chain[g+1]),
            .out_arr   (arr_chain[g+1]),
            .out_bst   (bst_chain[g+1]),
            .out_rsp   (rsp_chain[g+1])
        );
    end

    // sequencer: walk, charge, finish
    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (tick_start) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (ctl_chain[MAX_SLOTS].valid) state_next = ST_UPD;
            end
            ST_UPD: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // wait for room in the result register
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // result beat assembly
    always_comb begin
        m_tdata_next = {1'b0, all_done,
                        OUT_TIME_W'(res_fin_reg ? res_rsp_reg : '0),
                        OUT_TIME_W'(res_fin_reg ? wait_time : '0),
                        OUT_TIME_W'(res_tat_reg),
                        OUT_TIME_W'(res_comp_reg),
                        SLOT_W'(res_slot_reg),
                        OUT_TIME_W'(res_tick_reg)};
        m_tuser_next = {res_fin_reg, res_idle_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            clock_reg        <= '0;
            completed_reg    <= '0;
            active_count_reg <= ACTIVE_COUNT_RESET;
            hold_ctl_reg     <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_write && (paddr[2] == REG_ACTIVE_COUNT)) begin
                active_count_reg <= pwdata[COUNT_W-1:0];
            end
            if (do_restart) begin
                clock_reg     <= '0;
                completed_reg <= '0;
            end else if (state_reg == ST_UPD) begin
                clock_reg <= clock_inc;
                if (fin_now) completed_reg <= completed_reg + 1'b1;
            end
            if ((state_reg == ST_SCAN) && ctl_chain[MAX_SLOTS].valid) begin
                hold_ctl_reg <= ctl_chain[MAX_SLOTS];
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_SCAN) && ctl_chain[MAX_SLOTS].valid) begin
            hold_rem_reg <= rem_chain[MAX_SLOTS];
            hold_idx_reg <= idx_chain[MAX_SLOTS];
            hold_arr_reg <= arr_chain[MAX_SLOTS];
            hold_bst_reg <= bst_chain[MAX_SLOTS];
            hold_rsp_reg <= rsp_chain[MAX_SLOTS];
        end
        if (state_reg == ST_UPD) begin
            res_tick_reg <= clock_reg;
            res_idle_reg <= !hold_ctl_reg.found;
            res_slot_reg <= hold_ctl_reg.found ? hold_idx_reg : '0;
            res_fin_reg  <= fin_now;
            res_comp_reg <= fin_now ? clock_inc : '0;
            res_tat_reg  <= fin_now ? clock_inc - TIME_BITS'(hold_arr_reg) : '0;
            // first run records the response now, later runs reuse the stored one
            res_rsp_reg  <= hold_ctl_reg.started ? hold_rsp_reg : rsp_new;
        end
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    // the token leaves the row only while the sequencer waits for it
    `SRT_ASSERT_IMPL(a_tail_in_scan, aclk, aresetn, ctl_chain[MAX_SLOTS].valid, state_reg == ST_SCAN)
    // a charged slot always had time left
    `SRT_ASSERT_IMPL(a_pick_nonzero, aclk, aresetn, charge, hold_rem_reg != 16'd0)
    // charge is always followed by the finish step
    `SRT_ASSERT_NEXT(a_upd_to_fin, aclk, aresetn, state_reg == ST_UPD, state_reg == ST_FIN)
    // the clock never runs backwards over a tick
    `SRT_ASSERT_NEXT(a_clock_mono, aclk, aresetn, state_reg == ST_UPD, clock_reg >= $past(clock_reg))

endmodule
